// File: src/prime_field_251_alu_top_macros.svh
// Assertion macros for the prime field ALU.
`ifndef PRIME_FIELD_251_ALU_TOP_MACROS_SVH
`define PRIME_FIELD_251_ALU_TOP_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define PF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("prime field ALU assertion failed");

// An implication checked in the same cycle.
`define PF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prime field ALU implication failed");

`else

`define PF_ASSERT(lbl, clk, rst_n, prop)
`define PF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/pf251_pkg.sv
// Package with the opcodes, defaults and the inverse table function of the prime field ALU.
package pf251_pkg;

  localparam int unsigned MODULUS_DEFAULT = 251;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } pf_cmd_e;

  // Smallest v in 1..m-1 with b*v == 1 modulo m, or 0 if there is none or if b is not below m.
  // The running product is kept reduced by one compare and subtract per step.
  function automatic logic [7:0] inverse_of(int unsigned m, int unsigned b);
    int unsigned acc;
    logic [7:0]  inv;
    acc = 0;
    inv = '0;
    if (b < m) begin
      for (int unsigned v = 1; v < m; v++) begin
        acc = acc + b;
        if (acc >= m) begin
          acc = acc - m;
        end
        if (acc == 1 && inv == 8'd0) begin
          inv = v[7:0];
        end
      end
    end
    return inv;
  endfunction

endpackage

// File: src/prime_field_251_alu_top.sv
// Pipelined arithmetic unit over the integers modulo MODULUS.
// Each transfer carries an opcode and two bytes; the unit reduces both bytes modulo MODULUS
// and returns their sum, difference, product or quotient modulo MODULUS. Division uses the
// inverse of the divisor from a constant table indexed by the reduced divisor; a divisor
// without an inverse (zero) gives a result of zero. The pipeline has five register stages,
// and a new item is taken in every cycle unless the pipeline is full and the output stalls:
// two stages reduce the operands by reciprocal multiplication, one forms the sum,
// difference or product, and two reduce the product. A stall at the output holds the
// pipeline only as far as bubbles cannot absorb it.
`include "prime_field_251_alu_top_macros.svh"

module prime_field_251_alu_top #(
  parameter int unsigned MODULUS = pf251_pkg::MODULUS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] operand_a_i,
  input  logic [7:0] operand_b_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] result_o
);

  // floor(2^16 / MODULUS): the quotient estimate is exact or one too small for values
  // below 2^16, so a single compare and subtract finishes each reduction.
  localparam logic [15:0] RecipW = 16'(65536 / MODULUS);
  localparam logic [7:0]  ModW   = 8'(MODULUS);
  localparam logic [8:0]  Mod9   = 9'(MODULUS);

  logic [7:0] inv_rom [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_inv
    assign inv_rom[gi] = pf251_pkg::inverse_of(MODULUS, gi);
  end

  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_valid_q || !out_stall_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = out_valid_q;

  // Stage 1: quotient estimates of both operands.
  pf251_pkg::pf_cmd_e s1_cmd_q;
  logic [7:0]  s1_a_q, s1_b_q, s1_qa_q, s1_qb_q;
  logic [7:0]  s1_qa_d, s1_qb_d;
  logic [23:0] mul_a, mul_b;

  assign mul_a   = 24'(operand_a_i) * 24'(RecipW);
  assign mul_b   = 24'(operand_b_i) * 24'(RecipW);
  assign s1_qa_d = mul_a[23:16];
  assign s1_qb_d = mul_b[23:16];

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_cmd_q <= pf251_pkg::pf_cmd_e'(cmd_i);
      s1_a_q   <= operand_a_i;
      s1_b_q   <= operand_b_i;
      s1_qa_q  <= s1_qa_d;
      s1_qb_q  <= s1_qb_d;
    end
  end

  // Stage 2: remainders of both operands.
  pf251_pkg::pf_cmd_e s2_cmd_q;
  logic [7:0]  s2_a_q, s2_b_q, s2_a_d, s2_b_d;
  logic [15:0] prod_qa, prod_qb, rem_a_full, rem_b_full;
  logic [8:0]  rem_a, rem_b;

  assign prod_qa    = 16'(s1_qa_q) * 16'(ModW);
  assign prod_qb    = 16'(s1_qb_q) * 16'(ModW);
  assign rem_a_full = 16'(s1_a_q) - prod_qa;
  assign rem_b_full = 16'(s1_b_q) - prod_qb;
  assign rem_a      = rem_a_full[8:0];
  assign rem_b      = rem_b_full[8:0];

  always_comb begin
    s2_a_d = (rem_a >= Mod9) ? 8'(rem_a - Mod9) : rem_a[7:0];
    s2_b_d = (rem_b >= Mod9) ? 8'(rem_b - Mod9) : rem_b[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_cmd_q <= s1_cmd_q;
      s2_a_q   <= s2_a_d;
      s2_b_q   <= s2_b_d;
    end
  end

  // Stage 3: sum or difference, and the product with b or with the inverse of b.
  pf251_pkg::pf_cmd_e s3_cmd_q;
  logic [15:0] s3_p_q, s3_p_d;
  logic [7:0]  s3_as_q, s3_as_d, mul_rhs;
  logic [8:0]  sum9, diff9, as9;

  assign mul_rhs = (s2_cmd_q == pf251_pkg::CMD_DIV) ? inv_rom[s2_b_q] : s2_b_q;
  assign s3_p_d  = 16'(s2_a_q) * 16'(mul_rhs);
  assign sum9    = 9'(s2_a_q) + 9'(s2_b_q);
  assign diff9   = 9'(s2_a_q) + Mod9 - 9'(s2_b_q);
  assign as9     = (s2_cmd_q == pf251_pkg::CMD_SUB) ? diff9 : sum9;
  assign s3_as_d = (as9 >= Mod9) ? 8'(as9 - Mod9) : as9[7:0];

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_cmd_q <= s2_cmd_q;
      s3_p_q   <= s3_p_d;
      s3_as_q  <= s3_as_d;
    end
  end

  // Stage 4: quotient estimate of the product.
  pf251_pkg::pf_cmd_e s4_cmd_q;
  logic [15:0] s4_p_q, s4_qp_q, s4_qp_d;
  logic [7:0]  s4_as_q;
  logic [31:0] mul_p;

  assign mul_p   = 32'(s3_p_q) * 32'(RecipW);
  assign s4_qp_d = mul_p[31:16];

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      s4_cmd_q <= s3_cmd_q;
      s4_p_q   <= s3_p_q;
      s4_qp_q  <= s4_qp_d;
      s4_as_q  <= s3_as_q;
    end
  end

  // Stage 5: remainder of the product and result selection.
  logic [23:0] prod_qp, rem_p_full;
  logic [8:0]  rem_p;
  logic [7:0]  prod_red, result_d, result_q;

  assign prod_qp    = 24'(s4_qp_q) * 24'(ModW);
  assign rem_p_full = 24'(s4_p_q) - prod_qp;
  assign rem_p      = rem_p_full[8:0];
  assign prod_red   = (rem_p >= Mod9) ? 8'(rem_p - Mod9) : rem_p[7:0];

  always_comb begin
    unique case (s4_cmd_q)
      pf251_pkg::CMD_ADD,
      pf251_pkg::CMD_SUB: result_d = s4_as_q;
      pf251_pkg::CMD_MUL,
      pf251_pkg::CMD_DIV: result_d = prod_red;
      default:            result_d = s4_as_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) out_valid_q <= v4_q;
    end
  end

  logic pipe_full;

  assign pipe_full = v1_q && v2_q && v3_q && v4_q && out_valid_q && out_stall_i;

  `PF_ASSERT_IMPLY(a_result_in_field, clk_i, rst_ni, out_valid_o, result_o < ModW)
  `PF_ASSERT_IMPLY(a_operands_reduced, clk_i, rst_ni, v2_q, (s2_a_q < ModW) && (s2_b_q < ModW))
  `PF_ASSERT_IMPLY(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, pipe_full)
  `PF_ASSERT(a_product_bound, clk_i, rst_ni, !v3_q || (s3_p_q <= 16'(s3_p_q[7:0]) + 16'd64770))

endmodule

// File: tb/prime_field_251_alu_top_tb.sv
// Self-checking testbench for the GF(251) arithmetic unit with random handshake pressure.
`timescale 1ns / 1ps

module prime_field_251_alu_top_tb;

  localparam int unsigned FIELD       = pf251_pkg::MODULUS_DEFAULT;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          PIPE_DEPTH  = 5;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  pf251_pkg::pf_cmd_e cmd_i       = pf251_pkg::CMD_ADD;
  logic [7:0]         operand_a_i = 8'd0;
  logic [7:0]         operand_b_i = 8'd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         result_o;

  logic [7:0] pending_results[$];
  logic [7:0] oldest_result;
  int         mismatches    = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;

  prime_field_251_alu_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Field result of one operation; both bytes are reduced first.
  function automatic logic [7:0] field_result(pf251_pkg::pf_cmd_e op, logic [7:0] a_raw,
                                              logic [7:0] b_raw);
    int unsigned a;
    int unsigned b;
    int unsigned inv;
    int unsigned v;
    int unsigned r;
    a   = a_raw % FIELD;
    b   = b_raw % FIELD;
    inv = 0;
    case (op)
      pf251_pkg::CMD_ADD: r = (a + b) % FIELD;
      pf251_pkg::CMD_SUB: r = (a + FIELD - b) % FIELD;
      pf251_pkg::CMD_MUL: r = (a * b) % FIELD;
      default: begin
        // Scanning downward leaves the smallest inverse; zero has none and stays 0.
        for (v = FIELD - 1; v >= 1; v--) begin
          if ((b * v) % FIELD == 1) begin
            inv = v;
          end
        end
        r = (a * inv) % FIELD;
      end
    endcase
    return r[7:0];
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("mismatch: %s, expected %0d, got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Input transfers queue their expected result; output transfers are checked in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(field_result(cmd_i, operand_a_i, operand_b_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 8'd0, result_o);
        end else begin
          oldest_result = pending_results.pop_front();
          if (result_o !== oldest_result) begin
            report_mismatch("result", oldest_result, result_o);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL prime_field_251_alu_top");
    $finish;
  end

  // Presents one item and returns at the edge of its transfer, valid still high.
  task automatic send_item(pf251_pkg::pf_cmd_e op, logic [7:0] a, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Biased toward 0, 1 and values around the modulus, where reduction matters.
  function automatic logic [7:0] pick_operand();
    logic [7:0] edges[8] = '{8'd0, 8'd1, 8'd249, 8'd250, 8'd251, 8'd252, 8'd254, 8'd255};
    if ($urandom_range(3) == 0) begin
      return edges[$urandom_range(7)];
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic test_operand_extremes();
    pf251_pkg::pf_cmd_e op;
    op = op.first();
    do begin
      send_item(op, 8'd0, 8'd0);
      send_item(op, 8'd255, 8'd255);
      send_item(op, 8'd250, 8'd250);
      send_item(op, 8'd251, 8'd5);
      send_item(op, 8'd3, 8'd252);
      op = op.next();
    end while (op != op.first());
  endtask

  task automatic test_special_cases();
    // Subtraction that goes below zero wraps around the modulus.
    send_item(pf251_pkg::CMD_SUB, 8'd1, 8'd250);
    send_item(pf251_pkg::CMD_SUB, 8'd0, 8'd1);
    // Divisors that reduce to zero give zero; a divisor of one returns the dividend.
    send_item(pf251_pkg::CMD_DIV, 8'd7, 8'd0);
    send_item(pf251_pkg::CMD_DIV, 8'd7, 8'd251);
    send_item(pf251_pkg::CMD_DIV, 8'd200, 8'd1);
  endtask

  task automatic test_random_traffic(int items, int idle_pct, int stall_in_pct);
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    repeat (items) begin
      send_item(pf251_pkg::pf_cmd_e'($urandom_range(3)), pick_operand(), pick_operand());
    end
    // The sender holds off here until every result has come back.
    wait_for_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operand_extremes();
    stall_pct = 81;
    test_special_cases();
    wait_for_drain();

    test_random_traffic(140, 0, 0);
    test_random_traffic(140, 81, 0);
    test_random_traffic(140, 0, 81);
    test_random_traffic(140, 6, 6);

    stall_pct = 0;
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never arrived", 8'(pending_results.size()), 8'd0);
    end

    if (mismatches == 0) begin
      $display("PASS prime_field_251_alu_top");
    end else begin
      $display("FAIL prime_field_251_alu_top");
    end
    $finish;
  end

endmodule

// File: prime_field_251_alu_top.f
+incdir+src
src/pf251_pkg.sv
src/prime_field_251_alu_top.sv
tb/prime_field_251_alu_top_tb.sv
